// ===== sv/nsv_pkg.sv =====
// shared types, character codes and helper functions for the nmea sentence validator
`default_nettype none
package nsv_pkg;

  localparam int NSV_MAX_DATA   = 128;
  localparam int NSV_MAX_FIELDS = 64;
  localparam int ADDR_LEN       = 5;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [6:0] START_CAP = 7'd127;
  localparam logic [6:0] LEN_CAP   = 7'd127;
  localparam logic [5:0] INDEX_CAP = 6'd63;

  typedef enum logic [2:0] {
    PH_SIG   = 3'd0,
    PH_ADDR  = 3'd1,
    PH_DATA  = 3'd2,
    PH_HEXHI = 3'd3,
    PH_HEXLO = 3'd4,
    PH_CR    = 3'd5,
    PH_LF    = 3'd6
  } phase_t;

  typedef enum logic {
    KIND_FIELD  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    logic       result_kind;
    logic [5:0] field_index;
    logic [6:0] field_start;
    logic [6:0] field_length;
    logic       bad_format;
    logic       bad_checksum;
    logic       bad_data;
    logic       corrupt;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
  } nsv_result_t;

  function automatic logic char_allowed(input logic [7:0] b);
    char_allowed = b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                             CH_DOT, CH_COMMA, CH_STAR, CH_DOLLAR, CH_BANG};
  endfunction

  // bit 4 set when the byte is a hex digit, low nibble is its value (0 otherwise)
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    hex_decode = r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/nsv_byte_if.sv =====
// byte input channel
`default_nettype none
interface nsv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== sv/nsv_result_if.sv =====
// result output channel
`default_nettype none
interface nsv_result_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [5:0] field_index;
  logic [6:0] field_start;
  logic [6:0] field_length;
  logic       bad_format;
  logic       bad_checksum;
  logic       bad_data;
  logic       corrupt;
  logic [7:0] computed_checksum;
  logic [7:0] received_checksum;

  modport source (output valid, output result_kind, output field_index,
                  output field_start, output field_length, output bad_format,
                  output bad_checksum, output bad_data, output corrupt,
                  output computed_checksum, output received_checksum,
                  input ready);
  modport sink   (input valid, input result_kind, input field_index,
                  input field_start, input field_length, input bad_format,
                  input bad_checksum, input bad_data, input corrupt,
                  input computed_checksum, input received_checksum,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/nmea_sentence_validator.sv =====
// top level: input register, sentence parser and result register
//
//  channel | dir | payload                                | handshake
//  rx      | in  | rx_byte                                | valid/ready
//  res     | out | kind, field index/start/length, flags, | valid/ready
//          |     | computed and received checksums        |
//
// one byte per cycle sustained while results are taken; a byte is held in the input register,
// then the parser updates its state and any result lands in the result register.
// synchronous reset returns the parser to the signature slot and empties both registers.
// a stalled result holds the parser and the input register; rx.ready then
// drops once the input register is full.
`default_nettype none
module nmea_sentence_validator #(
  parameter int MAX_DATA   = nsv_pkg::NSV_MAX_DATA,
  parameter int MAX_FIELDS = nsv_pkg::NSV_MAX_FIELDS
) (
  input wire logic     clk,
  input wire logic     rst,
  nsv_byte_if.sink     rx,
  nsv_result_if.source res
);

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 adv;
  logic                 p_valid;
  nsv_pkg::nsv_result_t p_res;
  logic                 out_valid;
  nsv_pkg::nsv_result_t out_data;

  assign adv      = !out_valid || res.ready;
  assign rx.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  nsv_parser #(
    .MAX_DATA   (MAX_DATA),
    .MAX_FIELDS (MAX_FIELDS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .en        (s1_valid && adv),
    .rx_data   (s1_byte),
    .res_valid (p_valid),
    .res       (p_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= p_res;
    end
  end

  assign res.valid             = out_valid;
  assign res.result_kind       = out_data.result_kind;
  assign res.field_index       = out_data.field_index;
  assign res.field_start       = out_data.field_start;
  assign res.field_length      = out_data.field_length;
  assign res.bad_format        = out_data.bad_format;
  assign res.bad_checksum      = out_data.bad_checksum;
  assign res.bad_data          = out_data.bad_data;
  assign res.corrupt           = out_data.corrupt;
  assign res.computed_checksum = out_data.computed_checksum;
  assign res.received_checksum = out_data.received_checksum;

  // parser only produces a result for a byte it is consuming
  a_result_needs_byte: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (s1_valid && adv))
    else $error("parser result without a consumed byte");

  // a byte waiting on a stalled result stays put
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> (s1_valid && $stable(s1_byte)))
    else $error("input register lost a byte during stall");

  // field results carry no status content
  a_field_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.result_kind == nsv_pkg::KIND_FIELD)) |->
      (!out_data.bad_format && !out_data.bad_checksum && !out_data.bad_data &&
       !out_data.corrupt && (out_data.computed_checksum == 8'd0) &&
       (out_data.received_checksum == 8'd0)))
    else $error("field result carries status bits");

  // corrupt summarizes format and checksum verdicts
  a_corrupt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.corrupt == (out_data.bad_format || out_data.bad_checksum)))
    else $error("corrupt flag inconsistent");

endmodule
`default_nettype wire

// ===== sv/nsv_parser.sv =====
// sentence state and per-byte parse logic
`default_nettype none
module nsv_parser #(
  parameter int MAX_DATA   = nsv_pkg::NSV_MAX_DATA,
  parameter int MAX_FIELDS = nsv_pkg::NSV_MAX_FIELDS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic [7:0]          rx_data,
  output logic                     res_valid,
  output nsv_pkg::nsv_result_t     res
);

  localparam int DW  = $clog2(MAX_DATA);
  localparam int FW  = $clog2(MAX_FIELDS);
  localparam int DCW = (DW > 7) ? DW : 7;
  localparam int FCW = (FW > 6) ? FW : 6;
  localparam logic [DW-1:0] DATA_CAP  = DW'(MAX_DATA - 1);
  localparam logic [FW-1:0] FIELD_CAP = FW'(MAX_FIELDS - 1);

  function automatic logic [6:0] clamp_d(input logic [DW-1:0] v);
    logic [DCW-1:0] x;
    x = DCW'(v);
    clamp_d = (x > DCW'(127)) ? 7'd127 : x[6:0];
  endfunction

  function automatic logic [5:0] clamp_f(input logic [FW-1:0] v);
    logic [FCW-1:0] x;
    x = FCW'(v);
    clamp_f = (x > FCW'(63)) ? nsv_pkg::INDEX_CAP : x[5:0];
  endfunction

  nsv_pkg::phase_t phase, phase_next;
  logic [2:0]    addr_cnt, addr_cnt_next;
  logic [7:0]    xor_acc, xor_acc_next;
  logic [DW-1:0] data_len, data_len_next;
  logic          field_open, field_open_next;
  logic [FW-1:0] field_cnt, field_cnt_next;
  logic [DW-1:0] field_start, field_start_next;
  logic [7:0]    rcv, rcv_next;
  logic          err_fmt, err_fmt_next;
  logic          err_data, err_data_next;

  logic          close;
  logic [DW-1:0] close_end;
  logic [DW-1:0] close_len;
  logic [4:0]    hex;
  logic          fmt_f, dat_f, chk_f;

  assign hex = nsv_pkg::hex_decode(rx_data);

  always_comb begin
    phase_next       = phase;
    addr_cnt_next    = addr_cnt;
    xor_acc_next     = xor_acc;
    data_len_next    = data_len;
    field_open_next  = field_open;
    field_cnt_next   = field_cnt;
    field_start_next = field_start;
    rcv_next         = rcv;
    err_fmt_next     = err_fmt;
    err_data_next    = err_data;
    close            = 1'b0;
    close_end        = data_len;
    res_valid        = 1'b0;
    res              = '0;
    fmt_f            = 1'b0;
    dat_f            = 1'b0;
    chk_f            = 1'b0;

    case (phase)
      nsv_pkg::PH_SIG: begin
        addr_cnt_next    = 3'd0;
        xor_acc_next     = 8'd0;
        data_len_next    = '0;
        field_open_next  = 1'b0;
        field_cnt_next   = '0;
        field_start_next = '0;
        rcv_next         = 8'd0;
        err_data_next    = 1'b0;
        err_fmt_next     = !(rx_data == nsv_pkg::CH_DOLLAR || rx_data == nsv_pkg::CH_BANG);
        phase_next       = nsv_pkg::PH_ADDR;
      end
      nsv_pkg::PH_ADDR: begin
        xor_acc_next  = xor_acc ^ rx_data;
        addr_cnt_next = addr_cnt + 3'd1;
        if (addr_cnt_next >= 3'(nsv_pkg::ADDR_LEN)) begin
          phase_next = nsv_pkg::PH_DATA;
        end
      end
      nsv_pkg::PH_DATA: begin
        if (rx_data == nsv_pkg::CH_STAR) begin
          close      = field_open;
          phase_next = nsv_pkg::PH_HEXHI;
        end else if (rx_data == nsv_pkg::CH_CR) begin
          // missing star: data ends here and the checksum slots are skipped
          err_fmt_next = 1'b1;
          close        = field_open;
          phase_next   = nsv_pkg::PH_LF;
        end else begin
          xor_acc_next = xor_acc ^ rx_data;
          if (!nsv_pkg::char_allowed(rx_data)) begin
            err_data_next = 1'b1;
          end
          if (data_len < DATA_CAP) begin
            data_len_next = data_len + DW'(1);
          end
          if (rx_data == nsv_pkg::CH_COMMA) begin
            close            = field_open;
            field_open_next  = 1'b1;
            field_start_next = (data_len == DATA_CAP) ? DATA_CAP : data_len + DW'(1);
            if (field_cnt < FIELD_CAP) begin
              field_cnt_next = field_cnt + FW'(1);
            end
          end
        end
      end
      nsv_pkg::PH_HEXHI: begin
        if (!hex[4]) begin
          err_fmt_next = 1'b1;
        end
        rcv_next   = rcv | {hex[3:0], 4'd0};
        phase_next = nsv_pkg::PH_HEXLO;
      end
      nsv_pkg::PH_HEXLO: begin
        if (!hex[4]) begin
          err_fmt_next = 1'b1;
        end
        rcv_next   = rcv | {4'd0, hex[3:0]};
        phase_next = nsv_pkg::PH_CR;
      end
      nsv_pkg::PH_CR: begin
        if (rx_data != nsv_pkg::CH_CR) begin
          err_fmt_next = 1'b1;
        end
        phase_next = nsv_pkg::PH_LF;
      end
      default: begin
        fmt_f         = err_fmt || (rx_data != nsv_pkg::CH_LF);
        dat_f         = err_data || (data_len == '0);
        chk_f         = rcv != xor_acc;
        err_fmt_next  = fmt_f;
        err_data_next = dat_f;
        res_valid     = 1'b1;
        res.result_kind       = nsv_pkg::KIND_STATUS;
        res.field_index       = clamp_f(field_cnt);
        res.bad_format        = fmt_f;
        res.bad_checksum      = chk_f;
        res.bad_data          = dat_f;
        res.corrupt           = fmt_f || chk_f;
        res.computed_checksum = xor_acc;
        res.received_checksum = rcv;
        phase_next            = nsv_pkg::PH_SIG;
      end
    endcase

    // field close: the field ends just before the current data offset
    close_len = (close_end >= field_start) ? close_end - field_start : '0;
    if (close) begin
      field_open_next       = (phase == nsv_pkg::PH_DATA) && (rx_data == nsv_pkg::CH_COMMA);
      res_valid             = 1'b1;
      res                   = '0;
      res.result_kind       = nsv_pkg::KIND_FIELD;
      res.field_index       = clamp_f((field_cnt != '0) ? field_cnt - FW'(1) : '0);
      res.field_start       = clamp_d(field_start);
      res.field_length      = clamp_d(close_len);
    end
    res_valid = res_valid && en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= nsv_pkg::PH_SIG;
      addr_cnt    <= 3'd0;
      xor_acc     <= 8'd0;
      data_len    <= '0;
      field_open  <= 1'b0;
      field_cnt   <= '0;
      field_start <= '0;
      rcv         <= 8'd0;
      err_fmt     <= 1'b0;
      err_data    <= 1'b0;
    end else if (en) begin
      phase       <= phase_next;
      addr_cnt    <= addr_cnt_next;
      xor_acc     <= xor_acc_next;
      data_len    <= data_len_next;
      field_open  <= field_open_next;
      field_cnt   <= field_cnt_next;
      field_start <= field_start_next;
      rcv         <= rcv_next;
      err_fmt     <= err_fmt_next;
      err_data    <= err_data_next;
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb_nmea_sentence_validator.sv =====
// testbench for nmea_sentence_validator: byte stimulus, sentence predictor and result checker
`timescale 1ns / 1ps
module tb_nmea_sentence_validator;

  logic clk = 1'b0;
  logic rst;

  nsv_byte_if   rx();
  nsv_result_if res();

  nmea_sentence_validator dut (
    .clk(clk),
    .rst(rst),
    .rx (rx),
    .res(res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [7:0]           byte_q[$];
  nsv_pkg::nsv_result_t pending_results[$];
  int unsigned queued_bytes   = 0;
  int unsigned accepted_bytes = 0;
  int unsigned mismatches     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // sentence tracker state, mirrors the parser
  nsv_pkg::phase_t ph      = nsv_pkg::PH_SIG;
  int unsigned addr_seen   = 0;
  int unsigned data_len    = 0;
  int unsigned field_cnt   = 0;
  int unsigned field_first = 0;
  logic        field_live  = 1'b0;
  logic        fmt_bad     = 1'b0;
  logic        data_bad    = 1'b0;
  logic [7:0]  xor_sum     = 8'd0;
  logic [7:0]  sum_rx      = 8'd0;

  function automatic int unsigned saturate(int unsigned v, int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic bit is_sentence_char(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h30 && b <= 8'h39) || b == nsv_pkg::CH_DOT ||
           b == nsv_pkg::CH_COMMA || b == nsv_pkg::CH_STAR ||
           b == nsv_pkg::CH_DOLLAR || b == nsv_pkg::CH_BANG;
  endfunction

  function automatic int hex_nibble(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b) - 48;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 55;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 87;
    return -1;
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] v, bit lower);
    if (v < 10) return 8'h30 + v;
    return (lower ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  task automatic close_open_field(int unsigned end_pos);
    nsv_pkg::nsv_result_t r;
    int unsigned len;
    if (!field_live) return;
    len = (end_pos >= field_first) ? end_pos - field_first : 0;
    r = '0;
    r.result_kind  = nsv_pkg::KIND_FIELD;
    r.field_index  = 6'(saturate(field_cnt > 0 ? field_cnt - 1 : 0, nsv_pkg::INDEX_CAP));
    r.field_start  = 7'(saturate(field_first, nsv_pkg::START_CAP));
    r.field_length = 7'(saturate(len, nsv_pkg::LEN_CAP));
    pending_results.push_back(r);
    field_live = 1'b0;
  endtask

  task automatic take_checksum_digit(logic [7:0] b, int shift);
    int n;
    n = hex_nibble(b);
    if (n < 0) begin
      fmt_bad = 1'b1;
      n = 0;
    end
    sum_rx = sum_rx | 8'(n << shift);
  endtask

  task automatic track_sentence_byte(logic [7:0] b);
    nsv_pkg::nsv_result_t r;
    int unsigned pos;
    case (ph)
      nsv_pkg::PH_SIG: begin
        addr_seen   = 0;
        data_len    = 0;
        field_cnt   = 0;
        field_first = 0;
        field_live  = 1'b0;
        data_bad    = 1'b0;
        xor_sum     = 8'd0;
        sum_rx      = 8'd0;
        fmt_bad     = (b != nsv_pkg::CH_DOLLAR && b != nsv_pkg::CH_BANG);
        ph = nsv_pkg::PH_ADDR;
      end
      nsv_pkg::PH_ADDR: begin
        xor_sum = xor_sum ^ b;
        addr_seen++;
        if (addr_seen >= nsv_pkg::ADDR_LEN) ph = nsv_pkg::PH_DATA;
      end
      nsv_pkg::PH_DATA: begin
        if (b == nsv_pkg::CH_STAR) begin
          close_open_field(data_len);
          ph = nsv_pkg::PH_HEXHI;
        end else if (b == nsv_pkg::CH_CR) begin
          // missing star: data ends here, straight to the lf slot
          fmt_bad = 1'b1;
          close_open_field(data_len);
          ph = nsv_pkg::PH_LF;
        end else begin
          pos = data_len;
          xor_sum = xor_sum ^ b;
          if (!is_sentence_char(b)) data_bad = 1'b1;
          if (data_len < nsv_pkg::NSV_MAX_DATA - 1) data_len++;
          if (b == nsv_pkg::CH_COMMA) begin
            close_open_field(pos);
            field_live  = 1'b1;
            field_first = saturate(pos + 1, nsv_pkg::NSV_MAX_DATA - 1);
            if (field_cnt < nsv_pkg::NSV_MAX_FIELDS - 1) field_cnt++;
          end
        end
      end
      nsv_pkg::PH_HEXHI: begin
        take_checksum_digit(b, 4);
        ph = nsv_pkg::PH_HEXLO;
      end
      nsv_pkg::PH_HEXLO: begin
        take_checksum_digit(b, 0);
        ph = nsv_pkg::PH_CR;
      end
      nsv_pkg::PH_CR: begin
        if (b != nsv_pkg::CH_CR) fmt_bad = 1'b1;
        ph = nsv_pkg::PH_LF;
      end
      nsv_pkg::PH_LF: begin
        if (b != nsv_pkg::CH_LF) fmt_bad = 1'b1;
        if (data_len == 0) data_bad = 1'b1;
        r = '0;
        r.result_kind       = nsv_pkg::KIND_STATUS;
        r.field_index       = 6'(saturate(field_cnt, nsv_pkg::INDEX_CAP));
        r.bad_format        = fmt_bad;
        r.bad_checksum      = (sum_rx != xor_sum);
        r.bad_data          = data_bad;
        r.corrupt           = fmt_bad | (sum_rx != xor_sum);
        r.computed_checksum = xor_sum;
        r.received_checksum = sum_rx;
        pending_results.push_back(r);
        ph = nsv_pkg::PH_SIG;
      end
      default: ph = nsv_pkg::PH_SIG;
    endcase
  endtask

  task automatic push_byte(logic [7:0] b);
    byte_q.push_back(b);
    queued_bytes++;
  endtask

  task automatic push_text(string s);
    foreach (s[i]) push_byte(s[i]);
  endtask

  // signature, body, star, correct checksum and crlf
  task automatic push_framed(logic [7:0] sig, string body, bit lower);
    logic [7:0] sum;
    sum = 8'd0;
    push_byte(sig);
    foreach (body[i]) begin
      push_byte(body[i]);
      sum = sum ^ body[i];
    end
    push_byte(nsv_pkg::CH_STAR);
    push_byte(hex_digit(sum[7:4], lower));
    push_byte(hex_digit(sum[3:0], lower));
    push_byte(nsv_pkg::CH_CR);
    push_byte(nsv_pkg::CH_LF);
  endtask

  // mostly well-formed sentence; star and cr never appear inside the data
  task automatic gen_sentence(int n_data, int comma_pct);
    string      legal;
    logic [7:0] sum;
    logic [7:0] b;
    int         pick;
    int         tail;
    bit         lower;
    legal = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.$!";
    sum = 8'd0;
    pick = $urandom_range(99);
    push_byte(pick < 45 ? nsv_pkg::CH_DOLLAR : pick < 90 ? nsv_pkg::CH_BANG
                                                        : 8'($urandom_range(255)));
    for (int i = 0; i < nsv_pkg::ADDR_LEN; i++) begin
      b = ($urandom_range(99) < 80) ? 8'($urandom_range(8'h5A, 8'h41))
                                    : 8'($urandom_range(255));
      push_byte(b);
      sum = sum ^ b;
    end
    for (int i = 0; i < n_data; i++) begin
      pick = $urandom_range(99);
      if ((i == 0 && pick < 85) || (i > 0 && pick < comma_pct)) begin
        b = nsv_pkg::CH_COMMA;
      end else if (pick < 93) begin
        b = legal[$urandom_range(legal.len() - 1)];
      end else begin
        do b = 8'($urandom_range(255));
        while (b == nsv_pkg::CH_STAR || b == nsv_pkg::CH_CR);
      end
      push_byte(b);
      sum = sum ^ b;
    end
    tail = $urandom_range(99);
    lower = $urandom_range(1);
    if (tail >= 90) begin
      push_byte(nsv_pkg::CH_CR);
      push_byte(nsv_pkg::CH_LF);
    end else begin
      push_byte(nsv_pkg::CH_STAR);
      if (tail >= 70 && tail < 80) sum = sum ^ 8'($urandom_range(255, 1));
      if (tail >= 80 && tail < 88) begin
        push_byte(8'($urandom_range(255)));
        push_byte(8'($urandom_range(255)));
      end else begin
        push_byte(hex_digit(sum[7:4], lower));
        push_byte(hex_digit(sum[3:0], lower));
      end
      push_byte($urandom_range(99) < 92 ? nsv_pkg::CH_CR : 8'($urandom_range(255)));
      push_byte($urandom_range(99) < 92 ? nsv_pkg::CH_LF : 8'($urandom_range(255)));
    end
  endtask

  task automatic compare_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    nsv_pkg::nsv_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %0d index %0d",
               $time, res.result_kind, res.field_index);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("result_kind", want.result_kind, res.result_kind);
    compare_field("field_index", want.field_index, res.field_index);
    compare_field("field_start", want.field_start, res.field_start);
    compare_field("field_length", want.field_length, res.field_length);
    compare_field("bad_format", want.bad_format, res.bad_format);
    compare_field("bad_checksum", want.bad_checksum, res.bad_checksum);
    compare_field("bad_data", want.bad_data, res.bad_data);
    compare_field("corrupt", want.corrupt, res.corrupt);
    compare_field("computed_checksum", want.computed_checksum, res.computed_checksum);
    compare_field("received_checksum", want.received_checksum, res.received_checksum);
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      rx.valid   <= 1'b0;
      rx.rx_byte <= 8'd0;
    end else begin
      if (rx.valid && rx.ready) begin
        track_sentence_byte(rx.rx_byte);
        accepted_bytes++;
      end
      if (!rx.valid || rx.ready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx.valid   <= 1'b1;
          rx.rx_byte <= byte_q.pop_front();
        end else begin
          rx.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) check_result();
      res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int unsigned goal;
    rst        = 1'b1;
    rx.valid   = 1'b0;
    rx.rx_byte = 8'd0;
    res.ready  = 1'b0;

    // clean sentences, lower and upper case checksum, empty field
    push_framed(nsv_pkg::CH_BANG, "GPABC,x,Y9.", 1'b1);
    push_framed(nsv_pkg::CH_DOLLAR, "GPGGA,,1234", 1'b0);
    // wrong signature, bad data bytes, non-hex digits, broken terminator
    push_text("#ABCDE");
    push_byte(8'h00);
    push_byte(nsv_pkg::CH_COMMA);
    push_byte(8'hFF);
    push_byte(nsv_pkg::CH_LF);
    push_text("*Gz");
    push_byte(nsv_pkg::CH_LF);
    push_text("X");
    // bytes before the first comma, then cr with no star
    push_text("$ABCDE12,3");
    push_byte(nsv_pkg::CH_CR);
    push_byte(nsv_pkg::CH_LF);
    // empty data section
    push_framed(nsv_pkg::CH_DOLLAR, "ABCDE", 1'b0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      goal = queued_bytes + 125;
      // long sentence drives the length and field counters into saturation
      if (p == 2) gen_sentence(140, 50);
      while (queued_bytes < goal) begin
        if ($urandom_range(99) < 2) gen_sentence(140, 50);
        else gen_sentence($urandom_range(24), 25);
      end
      while (byte_q.size() != 0) @(posedge clk);
    end

    while (accepted_bytes != queued_bytes || pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("nmea_sentence_validator test passed");
    end else begin
      $display("nmea_sentence_validator test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("nmea_sentence_validator test failed");
    $finish;
  end

endmodule
